// File: sv/bbcs_pkg.sv
// Shared types, field widths and mask helpers for the bitplane blit copy setup block.
// No dependencies; used by bbcs_offset and bitplane_blit_copy_setup.
package bbcs_pkg;

	localparam int IN_BITS  = 104;	// 97 field bits, padded to whole bytes
	localparam int OUT_BITS = 144;	// 139 field bits, padded to whole bytes

	localparam int COORD_W  = 11;
	localparam int WIDTH_W  = 10;
	localparam int HEIGHT_W = 11;
	localparam int PITCH_W  = 8;
	localparam int DEPTH_W  = 4;
	localparam int LOGIC_W  = 8;
	localparam int WORDS_W  = 7;
	localparam int MOD_W    = 16;
	localparam int OFF_W    = 20;
	localparam int IDX_W    = 13;	// signed row/column work width

	localparam logic [15:0] MASK_ALL   = 16'hFFFF;
	localparam logic [4:0]  WORD_BITS  = 5'd16;

	// stage advance strobes handed to the offset datapath
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} bbcs_adv_t;

	// left-shifted word mask; a shift of 16 or more clears it
	function automatic logic [15:0] mask_shl(input logic [4:0] s);
		mask_shl = s[4] ? 16'h0000 : (MASK_ALL << s[3:0]);
	endfunction

	// right-shifted word mask; a shift of 16 or more clears it
	function automatic logic [15:0] mask_shr(input logic [4:0] s);
		mask_shr = s[4] ? 16'h0000 : (MASK_ALL >> s[3:0]);
	endfunction

endpackage

// File: sv/bbcs_offset.sv
// Byte offset of a start word: row index times pitch plus the floored byte column.
// Two register stages (product, then sum). Depends on bbcs_pkg.
module bbcs_offset (
	input  logic                                clk,
	input  bbcs_pkg::bbcs_adv_t                 adv,
	input  logic signed [bbcs_pkg::IDX_W-1:0]   row,	// stage-1 register
	input  logic        [bbcs_pkg::PITCH_W-1:0] pitch,	// stage-1 register
	input  logic signed [bbcs_pkg::IDX_W-1:0]   col,	// stage-1 register, bit column
	output logic        [bbcs_pkg::OFF_W-1:0]   offset
);
	import bbcs_pkg::*;

	logic [OFF_W-1:0] row_ext;
	logic [OFF_W-1:0] pitch_ext;
	logic [OFF_W-1:0] prod_s2;
	logic [OFF_W-1:0] colb_s2;
	logic [OFF_W-1:0] offset_s3;

	// sign-extend so a row of minus one wraps the product modulo 2^20
	assign row_ext   = OFF_W'(row);
	assign pitch_ext = {{(OFF_W-PITCH_W){1'b0}}, pitch};

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			prod_s2 <= OFF_W'(row_ext * pitch_ext);
			colb_s2 <= OFF_W'(col >>> 3);	// floor toward minus infinity
		end
		if (adv.en_s3) begin
			offset_s3 <= prod_s2 + colb_s2;
		end
	end

	assign offset = offset_s3;

endmodule

// File: sv/bitplane_blit_copy_setup.sv
// Top level of the bitplane blit copy setup block: stream ports and the three-stage pipeline.
// Depends on bbcs_pkg and bbcs_offset.
//
// Takes one rectangle-copy request per transfer and returns one blitter setup per request,
// in order. The block is fully pipelined over three register stages: a new request can be
// taken every clock cycle while the output side is not stalled, and each result passes the
// stage 1, stage 2 and stage 3 registers in turn before it is presented on the output.
// Stage 1 picks ascending or descending mode and the
// blit width; stage 2 builds the masks, shift, modulos and the row-times-pitch products;
// stage 3 adds the byte columns into the start offsets and holds the result for the output
// transfer. The row-times-pitch multiply (13 by 8 bits) sets the depth of stage 2. Each
// stage moves forward when the stage after it is empty or moving, so empty stages fill
// while a finished result waits and a stall on the output loses or repeats nothing. The
// block keeps no state between requests; reset only clears the stage valid bits.
module bitplane_blit_copy_setup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// src_x, src_y, dst_x, dst_y, copy_width, copy_height, src_bytes_per_row,
	// dst_bytes_per_row, src_depth, dst_depth, logic_function, zero pad
	input  logic [bbcs_pkg::IN_BITS-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// descending, shift_amount, first_word_mask, last_word_mask, row_words, rows,
	// src_modulo, dst_modulo, src_offset, dst_offset, plane_count, logic_out, zero pad
	output logic [bbcs_pkg::OUT_BITS-1:0] m_axis_tdata
);
	import bbcs_pkg::*;

	// request fields
	logic [COORD_W-1:0]  src_x, src_y, dst_x, dst_y;
	logic [WIDTH_W-1:0]  copy_width;
	logic [HEIGHT_W-1:0] copy_height;
	logic [PITCH_W-1:0]  src_bytes_per_row, dst_bytes_per_row;
	logic [DEPTH_W-1:0]  src_depth, dst_depth;
	logic [LOGIC_W-1:0]  logic_function;

	assign src_x             = s_axis_tdata[10:0];
	assign src_y             = s_axis_tdata[21:11];
	assign dst_x             = s_axis_tdata[32:22];
	assign dst_y             = s_axis_tdata[43:33];
	assign copy_width        = s_axis_tdata[53:44];
	assign copy_height       = s_axis_tdata[64:54];
	assign src_bytes_per_row = s_axis_tdata[72:65];
	assign dst_bytes_per_row = s_axis_tdata[80:73];
	assign src_depth         = s_axis_tdata[84:81];
	assign dst_depth         = s_axis_tdata[88:85];
	assign logic_function    = s_axis_tdata[96:89];

	// ---------------------------------------------------------------- handshake
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	bbcs_adv_t adv;

	assign rdy_s3 = !v_s3 || m_axis_tready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;
	assign m_axis_tvalid = v_s3;
	assign adv.en_s2 = rdy_s2;
	assign adv.en_s3 = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// mode choice, blit width, start rows and columns, plane count
	logic [3:0]          sd, dd, mx, wd, fs;
	logic [10:0]         w_sd, bw_asc, bw_desc;
	logic signed [11:0]  slack;
	logic                desc;
	logic [IDX_W-1:0]    srow, drow, scol, dcol;

	assign sd      = src_x[3:0];
	assign dd      = dst_x[3:0];
	assign w_sd    = {1'b0, copy_width} + {7'b0, sd};
	assign bw_asc  = ({1'b0, copy_width} + {7'b0, dd} + 11'd15) & 11'h7F0;
	assign slack   = $signed({1'b0, bw_asc}) - $signed({1'b0, w_sd});
	assign desc    = (sd > dd) || (slack > 12'sd16);
	assign mx      = (sd > dd) ? sd : dd;
	assign bw_desc = ({1'b0, copy_width} + {7'b0, mx} + 11'd15) & 11'h7F0;
	assign wd      = w_sd[3:0];
	assign fs      = 4'(4'd0 - wd);	// pad up to the next word edge

	// descending starts at the last word of the last row
	assign srow = desc ? ({2'b0, src_y} + {2'b0, copy_height} - 13'd1) : {2'b0, src_y};
	assign drow = desc ? ({2'b0, dst_y} + {2'b0, copy_height} - 13'd1) : {2'b0, dst_y};
	assign scol = desc ? ({2'b0, src_x} + {3'b0, copy_width} + {9'b0, fs} - 13'd1)
	                   : {2'b0, src_x};
	assign dcol = desc ? ({2'b0, dst_x} + {3'b0, copy_width} + {9'b0, fs} - 13'd1)
	                   : {2'b0, dst_x};

	logic                desc_s1;
	logic [3:0]          sd_s1, dd_s1, fs_s1;
	logic [10:0]         bw_s1;
	logic [WIDTH_W-1:0]  w_s1;
	logic [HEIGHT_W-1:0] rows_s1;
	logic [PITCH_W-1:0]  sbpr_s1, dbpr_s1;
	logic [DEPTH_W-1:0]  planes_s1;
	logic [LOGIC_W-1:0]  logic_s1;
	logic [IDX_W-1:0]    srow_s1, drow_s1, scol_s1, dcol_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			desc_s1   <= desc;
			sd_s1     <= sd;
			dd_s1     <= dd;
			fs_s1     <= fs;
			bw_s1     <= desc ? bw_desc : bw_asc;
			w_s1      <= copy_width;
			rows_s1   <= copy_height;
			sbpr_s1   <= src_bytes_per_row;
			dbpr_s1   <= dst_bytes_per_row;
			planes_s1 <= (src_depth < dst_depth) ? src_depth : dst_depth;
			logic_s1  <= logic_function;
			srow_s1   <= srow;
			drow_s1   <= drow;
			scol_s1   <= scol;
			dcol_s1   <= dcol;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// last-word shift, masks, barrel shift, word count, modulos
	logic [3:0]         sub;
	logic [10:0]        ls_full;
	logic [4:0]         ls;
	logic [15:0]        fmask, lmask, fcut;
	logic [3:0]         shift;
	logic [WORDS_W-1:0] words;

	assign sub     = desc_s1 ? fs_s1 : sd_s1;
	assign ls_full = bw_s1 - {1'b0, w_s1} - {7'b0, sub};
	assign ls      = ls_full[4:0];	// 0..31 in descending, 0..16 ascending
	// two-word descending case: the first mask also loses the overflow bits
	assign fcut    = (ls > WORD_BITS) ? mask_shr({1'b0, ls[3:0]}) : MASK_ALL;
	assign fmask   = desc_s1 ? (mask_shl({1'b0, fs_s1}) & fcut) : mask_shr({1'b0, sd_s1});
	assign lmask   = desc_s1 ? mask_shr(ls) : mask_shl(ls);
	assign shift   = desc_s1 ? 4'(ls[3:0] - dd_s1) : 4'(dd_s1 - sd_s1);
	assign words   = bw_s1[10:4];

	logic                desc_s2;
	logic [3:0]          shift_s2;
	logic [15:0]         fmask_s2, lmask_s2;
	logic [WORDS_W-1:0]  words_s2;
	logic [HEIGHT_W-1:0] rows_s2;
	logic [MOD_W-1:0]    smod_s2, dmod_s2;
	logic [DEPTH_W-1:0]  planes_s2;
	logic [LOGIC_W-1:0]  logic_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			desc_s2   <= desc_s1;
			shift_s2  <= shift;
			fmask_s2  <= fmask;
			lmask_s2  <= lmask;
			words_s2  <= words;
			rows_s2   <= rows_s1;
			smod_s2   <= {8'b0, sbpr_s1} - {8'b0, words, 1'b0};
			dmod_s2   <= {8'b0, dbpr_s1} - {8'b0, words, 1'b0};
			planes_s2 <= planes_s1;
			logic_s2  <= logic_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// start offsets finish here; everything else is the output register
	logic [OFF_W-1:0] soff_s3, doff_s3;

	bbcs_offset u_src_off (
		.clk    (clk),
		.adv    (adv),
		.row    (srow_s1),
		.pitch  (sbpr_s1),
		.col    (scol_s1),
		.offset (soff_s3)
	);

	bbcs_offset u_dst_off (
		.clk    (clk),
		.adv    (adv),
		.row    (drow_s1),
		.pitch  (dbpr_s1),
		.col    (dcol_s1),
		.offset (doff_s3)
	);

	logic                desc_s3;
	logic [3:0]          shift_s3;
	logic [15:0]         fmask_s3, lmask_s3;
	logic [WORDS_W-1:0]  words_s3;
	logic [HEIGHT_W-1:0] rows_s3;
	logic [MOD_W-1:0]    smod_s3, dmod_s3;
	logic [DEPTH_W-1:0]  planes_s3;
	logic [LOGIC_W-1:0]  logic_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			desc_s3   <= desc_s2;
			shift_s3  <= shift_s2;
			fmask_s3  <= fmask_s2;
			lmask_s3  <= lmask_s2;
			words_s3  <= words_s2;
			rows_s3   <= rows_s2;
			smod_s3   <= smod_s2;
			dmod_s3   <= dmod_s2;
			planes_s3 <= planes_s2;
			logic_s3  <= logic_s2;
		end
	end

	// result packing, lowest field last in the list
	assign m_axis_tdata = {5'b0, logic_s3, planes_s3, doff_s3, soff_s3, dmod_s3, smod_s3,
	                       rows_s3, words_s3, lmask_s3, fmask_s3, shift_s3, desc_s3};

endmodule

// File: tb/bitplane_blit_copy_setup_checker.sv
// Scoreboard for the bitplane blit copy setup block: predicts each setup from its request.
// Watches both stream channels; depends on bbcs_pkg for the port widths.
module bitplane_blit_copy_setup_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [bbcs_pkg::IN_BITS-1:0]  s_axis_tdata,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [bbcs_pkg::OUT_BITS-1:0] m_axis_tdata,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUND16  = 32'h0000_FFF0;
	localparam int NIBBLE_HI = 32'h0000_00F0;
	localparam int REPORT_MAX = 10;

	// request fields, lowest bits last in the list
	typedef struct packed {
		logic [6:0]  pad;
		logic [7:0]  logic_function;
		logic [3:0]  dst_depth;
		logic [3:0]  src_depth;
		logic [7:0]  dst_bytes_per_row;
		logic [7:0]  src_bytes_per_row;
		logic [10:0] copy_height;
		logic [9:0]  copy_width;
		logic [10:0] dst_y;
		logic [10:0] dst_x;
		logic [10:0] src_y;
		logic [10:0] src_x;
	} request_t;

	typedef struct packed {
		logic [4:0]  pad;
		logic [7:0]  logic_out;
		logic [3:0]  plane_count;
		logic [19:0] dst_offset;
		logic [19:0] src_offset;
		logic [15:0] dst_modulo;
		logic [15:0] src_modulo;
		logic [10:0] rows;
		logic [6:0]  row_words;
		logic [15:0] last_word_mask;
		logic [15:0] first_word_mask;
		logic [3:0]  shift_amount;
		logic        descending;
	} setup_t;

	setup_t setups_due[$];

	function automatic logic [15:0] word_mask_left(input int s);
		return (s < 0 || s > 15) ? 16'h0000 : 16'(32'hFFFF << s);
	endfunction

	function automatic logic [15:0] word_mask_right(input int s);
		return (s < 0 || s > 15) ? 16'h0000 : 16'(32'hFFFF >> s);
	endfunction

	function automatic setup_t blit_setup_calc(input request_t r);
		int sx, sy, dx, dy, w, h, sp, dp;
		int s_ph, d_ph, w_ph, mx, bw, fs, ls, words;
		int unsigned soff, doff;
		setup_t o;
		sx = r.src_x;
		sy = r.src_y;
		dx = r.dst_x;
		dy = r.dst_y;
		w  = r.copy_width;
		h  = r.copy_height;
		sp = r.src_bytes_per_row;
		dp = r.dst_bytes_per_row;
		o = '0;
		s_ph = sx & 15;
		d_ph = dx & 15;
		w_ph = (s_ph + w) & 15;
		o.descending = (s_ph > d_ph) || ((((w + d_ph + 15) & ROUND16) - (w + s_ph)) > 16);
		if (o.descending) begin
			mx = (s_ph > d_ph) ? s_ph : d_ph;
			bw = (w + mx + 15) & ROUND16;
			fs = ((w_ph + 15) & NIBBLE_HI) - w_ph;
			ls = bw - (w + fs);
			o.first_word_mask = word_mask_left(fs);
			o.last_word_mask  = word_mask_right(ls);
			// two-word blit: the first mask also loses the overhang
			if (ls > 16)
				o.first_word_mask &= word_mask_right(ls - 16);
			o.shift_amount = 4'(bw - (d_ph + w + fs));
			// start on the last word of the last row; column rounds toward minus infinity
			soff = sp * (sy + h - 1) + ((sx + w + fs - 1) >>> 3);
			doff = dp * (dy + h - 1) + ((dx + w + fs - 1) >>> 3);
		end else begin
			bw = (w + d_ph + 15) & ROUND16;
			ls = bw - (w + s_ph);
			o.first_word_mask = word_mask_right(s_ph);
			o.last_word_mask  = word_mask_left(ls);
			o.shift_amount = 4'(d_ph - s_ph);
			soff = sp * sy + (sx >> 3);
			doff = dp * dy + (dx >> 3);
		end
		words = bw >>> 4;
		o.row_words   = 7'(words);
		o.rows        = r.copy_height;
		o.src_modulo  = 16'(sp - 2 * words);
		o.dst_modulo  = 16'(dp - 2 * words);
		o.src_offset  = 20'(soff);
		o.dst_offset  = 20'(doff);
		o.plane_count = (r.src_depth < r.dst_depth) ? r.src_depth : r.dst_depth;
		o.logic_out   = r.logic_function;
		return o;
	endfunction

	task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			if (errors < REPORT_MAX)
				$display("%0t: setup field %s expected %h got %h", $realtime, name, want, got);
			errors++;
		end
	endtask

	task automatic compare_setup(input setup_t e, input setup_t a);
		note_field("descending", 32'(e.descending), 32'(a.descending));
		note_field("shift_amount", 32'(e.shift_amount), 32'(a.shift_amount));
		note_field("first_word_mask", 32'(e.first_word_mask), 32'(a.first_word_mask));
		note_field("last_word_mask", 32'(e.last_word_mask), 32'(a.last_word_mask));
		note_field("row_words", 32'(e.row_words), 32'(a.row_words));
		note_field("rows", 32'(e.rows), 32'(a.rows));
		note_field("src_modulo", 32'(e.src_modulo), 32'(a.src_modulo));
		note_field("dst_modulo", 32'(e.dst_modulo), 32'(a.dst_modulo));
		note_field("src_offset", 32'(e.src_offset), 32'(a.src_offset));
		note_field("dst_offset", 32'(e.dst_offset), 32'(a.dst_offset));
		note_field("plane_count", 32'(e.plane_count), 32'(a.plane_count));
		note_field("logic_out", 32'(e.logic_out), 32'(a.logic_out));
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setups_due.delete();
			pending = 0;
		end else begin
			// result first: a request cannot come back on the edge it was taken
			if (m_axis_tvalid && m_axis_tready) begin
				if (setups_due.size() == 0) begin
					if (errors < REPORT_MAX)
						$display("%0t: setup transfer %h with none outstanding",
							$realtime, m_axis_tdata);
					errors++;
				end else begin
					compare_setup(setups_due.pop_front(), m_axis_tdata);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				setups_due.push_back(blit_setup_calc(s_axis_tdata));
			pending = setups_due.size();
		end
	end

endmodule

// File: tb/tb_bitplane_blit_copy_setup.sv
// Testbench top for bitplane_blit_copy_setup: clock, reset, request and result stream traffic.
// Depends on bbcs_pkg, the block, and bitplane_blit_copy_setup_checker for all checking.
module tb_bitplane_blit_copy_setup;
	timeunit 1ns;
	timeprecision 1ps;

	import bbcs_pkg::*;

	localparam int RANDOM_REQS  = 1330;
	localparam int MAX_GAP      = 12;
	localparam int HOLD_AT      = 300;	// result index where the sink holds off
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 20;	// pipeline is three stages deep
	localparam int PAUSE_AT     = 700;
	localparam longint LIMIT_NS = 4_000_000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_BITS-1:0]  s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_BITS-1:0] m_axis_tdata;

	int errors;
	int pending;

	// transfer counts taken and delivered, bumped at the rising edge and read at the falling edge
	int taken;
	int delivered;
	int sent;

	// per-phase switches for random idling on each side
	bit source_gaps = 1'b1;
	bit sink_gaps = 1'b1;

	always #5 clk = ~clk;

	bitplane_blit_copy_setup i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	bitplane_blit_copy_setup_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.errors       (errors),
		.pending      (pending)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken <= 0;
			delivered <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				taken <= taken + 1;
			if (m_axis_tvalid && m_axis_tready)
				delivered <= delivered + 1;
		end
	end

	// Request word: src_x, src_y, dst_x, dst_y, copy_width, copy_height,
	// src_bytes_per_row, dst_bytes_per_row, src_depth, dst_depth, logic_function (low bits first)
	function automatic logic [IN_BITS-1:0] pack_request(
		input logic [10:0] sx, input logic [10:0] sy,
		input logic [10:0] dx, input logic [10:0] dy,
		input logic [9:0] w, input logic [10:0] h,
		input logic [7:0] sp, input logic [7:0] dp,
		input logic [3:0] sdep, input logic [3:0] ddep,
		input logic [7:0] lf);
		return {7'b0000000, lf, ddep, sdep, dp, sp, h, w, dy, dx, sy, sx};
	endfunction

	// Mostly legal requests with small rectangles; one in ten uses the raw field widths
	// (zero size, zero pitch, zero or oversized depth).
	function automatic logic [IN_BITS-1:0] random_request();
		bit wide;
		logic [9:0] w;
		logic [10:0] h;
		logic [7:0] sp, dp;
		logic [3:0] sdep, ddep;
		wide = ($urandom_range(0, 9) == 0);
		if (wide) begin
			w = 10'($urandom_range(0, 1023));
			h = 11'($urandom_range(0, 2047));
			sp = 8'($urandom_range(0, 255));
			dp = 8'($urandom_range(0, 255));
			sdep = 4'($urandom_range(0, 15));
			ddep = 4'($urandom_range(0, 15));
		end else begin
			w = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(1, 64))
			                                : 10'($urandom_range(1, 1008));
			h = ($urandom_range(0, 3) != 0) ? 11'($urandom_range(1, 32))
			                                : 11'($urandom_range(1, 1024));
			sp = 8'($urandom_range(2, 254));
			dp = 8'($urandom_range(2, 254));
			sdep = 4'($urandom_range(1, 8));
			ddep = 4'($urandom_range(1, 8));
		end
		return pack_request(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
			11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
			w, h, sp, dp, sdep, ddep, 8'($urandom_range(0, 255)));
	endfunction

	// Offer one request and return at the falling edge after its transfer. With no gap
	// tvalid simply stays high, so it is never dropped and raised in one step.
	task automatic send_request(input logic [IN_BITS-1:0] req);
		int gap;
		gap = source_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= req;
		s_axis_tvalid <= 1'b1;
		sent++;
		while (taken != sent)
			@(negedge clk);
	endtask

	// Source goes quiet until every outstanding setup has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Result side: random stall before each transfer, one long hold-off while
	// the source keeps offering, so the pipeline fills and backs up its input.
	initial begin
		int n;
		int stall;
		n = 0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (n % 50 == 0)
				sink_gaps = ($urandom_range(0, 2) != 0);
			if (n == HOLD_AT) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			n++;
			while (delivered != n)
				@(negedge clk);
		end
	end

	initial begin
		sent = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, both modes and the corner cases
		send_request(pack_request(0, 0, 0, 0, 1, 1, 2, 2, 1, 1, 8'h00));
		send_request(pack_request(2047, 2047, 2047, 2047, 1008, 1024, 254, 254, 8, 8, 8'hFF));
		// descending on width slack with source phase below destination, then ascending at equal phases
		send_request(pack_request(3, 10, 12, 20, 40, 5, 40, 80, 4, 2, 8'hCA));
		send_request(pack_request(21, 7, 37, 9, 100, 3, 100, 60, 3, 5, 8'hC0));
		// descending on phase
		send_request(pack_request(15, 4, 16, 8, 2, 6, 20, 20, 2, 2, 8'hF0));
		send_request(pack_request(7, 100, 3, 50, 100, 12, 64, 128, 5, 5, 8'h0F));
		// descending on width slack
		send_request(pack_request(0, 1, 15, 2, 2, 2, 10, 10, 1, 8, 8'h5A));
		// two-word descending: first mask also trimmed
		send_request(pack_request(1, 30, 15, 40, 2, 9, 30, 30, 6, 7, 8'hA5));
		send_request(pack_request(5, 3, 31, 3, 10, 4, 16, 18, 8, 1, 8'h3C));
		// zero width in each mode
		send_request(pack_request(8, 5, 8, 5, 0, 4, 40, 40, 2, 2, 8'h33));
		send_request(pack_request(9, 5, 2, 5, 0, 4, 40, 40, 2, 2, 8'hCC));
		// zero height at row zero, ascending then descending: descending offsets go negative and wrap
		send_request(pack_request(0, 0, 4, 0, 16, 0, 80, 80, 3, 3, 8'h66));
		send_request(pack_request(12, 0, 1, 0, 33, 0, 80, 80, 3, 3, 8'h99));
		// zero depth and zero pitch go straight through
		send_request(pack_request(64, 64, 64, 64, 64, 8, 0, 0, 0, 4, 8'h01));
		send_request(pack_request(100, 1, 200, 1, 7, 1, 0, 254, 7, 0, 8'h80));
		// raw field maxima
		send_request(pack_request(2047, 2047, 2032, 2047, 1023, 2047, 255, 255, 15, 15, 8'hFE));
		send_request(pack_request(2032, 2047, 2047, 2047, 1023, 2047, 255, 255, 15, 9, 8'h7F));
		send_request(pack_request(1, 2047, 0, 0, 1023, 1, 255, 2, 9, 15, 8'h55));
		drain_results();

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 100 == 0)
				source_gaps = ($urandom_range(0, 2) != 0);
			// keep offering back to back across the sink's long hold-off
			if (i >= 250 && i < 520)
				source_gaps = 1'b0;
			if (i == PAUSE_AT)
				drain_results();
			send_request(random_request());
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_bitplane_blit_copy_setup: done, clean");
		else
			$display("tb_bitplane_blit_copy_setup: done, errors");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#(LIMIT_NS);
		$display("tb_bitplane_blit_copy_setup: done, errors");
		$finish;
	end

endmodule

// File: bitplane_blit_copy_setup.f
sv/bbcs_pkg.sv
sv/bbcs_offset.sv
sv/bitplane_blit_copy_setup.sv
tb/bitplane_blit_copy_setup_checker.sv
tb/tb_bitplane_blit_copy_setup.sv
